// ----- src/stq_pkg.sv -----
// Package for the sorted timer queue: widths, result kinds and entry type.
// Used by stq_delay and the top level; depends on nothing.
package stq_pkg;
    localparam int TIMERS    = 16;
    localparam int TIME_BITS = 48;
    localparam int IDX_BITS  = $clog2(TIMERS);
    localparam int CNT_BITS  = $clog2(TIMERS + 1);
    localparam int HBITS     = 8;
    localparam int DBITS     = 48;
    localparam logic [31:0] MIN_ARM_RESET = 32'd100000;

    typedef enum logic [1:0] {
        K_FIRED  = 2'd0,
        K_ARM    = 2'd1,
        K_NOARM  = 2'd2,
        K_REJECT = 2'd3
    } t_kind;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_EXPIRE = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0] dl;
        logic [TIME_BITS-1:0] iv;
        logic [HBITS-1:0]     h;
    } t_entry;

    typedef struct packed {
        t_kind            kind;
        logic [HBITS-1:0] h;
        logic [DBITS-1:0] delay;
        logic             last;
    } t_result;
endpackage

// ----- src/stq_ram.sv -----
// Generic single-port-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ABITS = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/stq_delay.sv -----
// Re-arm delay: deadline minus now, floored at zero and at the minimum, saturated.
// Depends on stq_pkg.
module stq_delay
    import stq_pkg::*;
(
    input  logic [TIME_BITS-1:0] i_dl,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [31:0]          i_min,
    output logic [DBITS-1:0]     o_delay
);
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS+32:0] wide;

    always_comb begin
        diff = (i_dl > i_now) ? (i_dl - i_now) : '0;
        wide = (TIME_BITS+33)'(diff);
        if (wide < (TIME_BITS+33)'(i_min)) begin
            wide = (TIME_BITS+33)'(i_min);
        end
        if (wide > (TIME_BITS+33)'({DBITS{1'b1}})) begin
            o_delay = {DBITS{1'b1}};
        end else begin
            o_delay = wide[DBITS-1:0];
        end
    end
endmodule

// ----- src/sorted_timer_queue_unit.sv -----
// Top level of the sorted timer queue: sequencer, APB register and entry memories.
// Depends on stq_pkg, stq_ram and stq_delay.
//
//  channel | dir | handshake         | payload
//  s_axis  | in  | tvalid/tready     | tdata {handle,iv,deadline,now}, tuser func
//  m_axis  | out | tvalid/tready     | tdata {delay,handle,kind}, tlast
//  apb     | in  | psel/penable      | reg 0 min_arm_delay at 0x0
//
// One item at a time. An add walks from the tail, reading each entry and then
// comparing and shifting it. An expire checks the due head (one fired result each),
// compacts the rest and reinserts each repeating timer by an add-style walk. Each
// memory sees at most one read and one write port access per cycle. Reset empties
// the table at once; output stalls hold the sequencer.
module sorted_timer_queue_unit
    import stq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [47:0] now_time, [95:48] deadline, [143:96] repeat_interval, [151:144] timer_handle
    input  logic [151:0] s_axis_tdata,
    // [0] func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] kind, [9:2] fired_handle, [57:10] arm_delay, [63:58] zero
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_ARD    = 12'b000000000010, // insert: read entry at scan
        S_ACMP   = 12'b000000000100, // insert: compare, shift down
        S_AWR    = 12'b000000001000, // insert: write new entry
        S_ERD    = 12'b000000010000, // expire: read head scan
        S_ECMP   = 12'b000000100000,
        S_CRD    = 12'b000001000000, // compaction read
        S_CWR    = 12'b000010000000,
        S_RRD    = 12'b000100000000, // reinsert: read the saved entry
        S_RNXT   = 12'b001000000000,
        S_HRD    = 12'b010000000000, // read head for final delay
        S_HFIN   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_BITS-1:0] r_occ, n_occ;
    logic [31:0] r_min;
    logic [TIME_BITS-1:0] r_now, n_now;
    t_entry r_new, n_new;
    logic [CNT_BITS-1:0] r_pos, n_pos;   // scan/shift pointer
    logic [CNT_BITS-1:0] r_k, n_k;       // count removed
    logic [CNT_BITS-1:0] r_j, n_j;       // reinsert index
    logic r_ins_exp, n_ins_exp;           // insert belongs to expire
    logic r_ovalid, n_ovalid;
    t_result r_out, n_out;

    // main table and a saved copy of removed entries
    logic tab_we, sav_we;
    logic [IDX_BITS-1:0] tab_wa, tab_ra, sav_wa, sav_ra;
    t_entry tab_wd, tab_rd, sav_rd;

    stq_ram #(.WIDTH($bits(t_entry)), .DEPTH(TIMERS), .ABITS(IDX_BITS)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_wa), .i_wdata(tab_wd),
        .i_raddr(tab_ra), .o_rdata(tab_rd)
    );
    stq_ram #(.WIDTH($bits(t_entry)), .DEPTH(TIMERS), .ABITS(IDX_BITS)) u_sav (
        .i_clk(i_clk), .i_we(sav_we), .i_waddr(sav_wa), .i_wdata(tab_rd),
        .i_raddr(sav_ra), .o_rdata(sav_rd)
    );

    logic [DBITS-1:0] dly;
    logic [TIME_BITS-1:0] dly_dl;
    stq_delay u_dly (.i_dl(dly_dl), .i_now(r_now), .i_min(r_min), .o_delay(dly));

    logic out_free;
    logic [TIME_BITS:0] sum;
    assign out_free = !r_ovalid || m_axis_tready;
    assign sum = {1'b0, r_now} + {1'b0, sav_rd.iv};

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_out.delay, r_out.h, r_out.kind};
    assign m_axis_tlast  = r_out.last;
    assign pready = 1'b1;
    assign prdata = r_min;

    always_comb begin
        n_state = r_state; n_occ = r_occ; n_now = r_now; n_new = r_new;
        n_pos = r_pos; n_k = r_k; n_j = r_j; n_ins_exp = r_ins_exp;
        n_ovalid = r_ovalid && !m_axis_tready; n_out = r_out;
        tab_we = 1'b0; tab_wa = r_pos[IDX_BITS-1:0]; tab_wd = r_new;
        tab_ra = r_pos[IDX_BITS-1:0];
        sav_we = 1'b0; sav_wa = r_pos[IDX_BITS-1:0]; sav_ra = r_j[IDX_BITS-1:0];
        dly_dl = r_new.dl;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_now = s_axis_tdata[TIME_BITS-1:0];
                    n_new.dl = s_axis_tdata[95:48];
                    n_new.iv = s_axis_tdata[143:96];
                    n_new.h  = s_axis_tdata[151:144];
                    n_ins_exp = 1'b0;
                    n_pos = '0;
                    if (s_axis_tuser == FUNC_EXPIRE) begin
                        n_k = '0;
                        n_state = S_ERD;
                    end else if (r_occ >= CNT_BITS'(TIMERS)) begin
                        n_out = '{kind: K_REJECT, h: '0, delay: '0, last: 1'b1};
                        n_ovalid = 1'b1;
                    end else begin
                        n_pos = r_occ;
                        n_state = S_ARD;
                    end
                end
            end
            // walk from the tail: shift entries with dl > new down by one
            S_ARD: begin
                if (r_pos == '0) begin
                    n_state = S_AWR;
                end else begin
                    tab_ra = IDX_BITS'(r_pos - 1'b1);
                    n_state = S_ACMP;
                end
            end
            S_ACMP: begin
                if (tab_rd.dl > r_new.dl) begin
                    tab_we = 1'b1; tab_wd = tab_rd;
                    n_pos = r_pos - 1'b1;
                    n_state = S_ARD;
                end else begin
                    n_state = S_AWR;
                end
            end
            S_AWR: begin
                if (out_free || r_ins_exp) begin
                    tab_we = 1'b1;
                    n_occ = r_occ + 1'b1;
                    if (r_ins_exp) begin
                        n_j = r_j + 1'b1;
                        n_state = S_RNXT;
                    end else begin
                        dly_dl = r_new.dl;
                        n_out = (r_pos == '0)
                            ? t_result'{kind: K_ARM, h: '0, delay: dly, last: 1'b1}
                            : t_result'{kind: K_NOARM, h: '0, delay: '0, last: 1'b1};
                        n_ovalid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERD: begin
                if (r_pos >= r_occ) begin
                    n_state = S_CRD;
                    n_pos = r_k;
                end else begin
                    n_state = S_ECMP;
                end
            end
            S_ECMP: begin
                if (tab_rd.dl < r_now) begin
                    if (out_free) begin
                        sav_we = 1'b1;
                        n_out = '{kind: K_FIRED, h: tab_rd.h, delay: '0, last: 1'b0};
                        n_ovalid = 1'b1;
                        n_pos = r_pos + 1'b1;
                        n_k = r_k + 1'b1;
                        n_state = S_ERD;
                    end
                end else begin
                    n_pos = r_k;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                if (r_pos >= r_occ) begin
                    n_occ = r_occ - r_k;
                    n_j = '0;
                    n_state = S_RNXT;
                end else begin
                    n_state = S_CWR;
                end
            end
            S_CWR: begin
                tab_we = 1'b1; tab_wd = tab_rd;
                tab_wa = IDX_BITS'(r_pos - r_k);
                n_pos = r_pos + 1'b1;
                tab_ra = IDX_BITS'(r_pos + 1'b1);
                n_state = S_CRD;
            end
            S_RNXT: begin
                if (r_j >= r_k) begin
                    tab_ra = '0;
                    n_state = S_HRD;
                end else begin
                    n_state = S_RRD;
                end
            end
            S_RRD: begin
                if (sav_rd.iv == '0) begin
                    n_j = r_j + 1'b1;
                    n_state = S_RNXT;
                end else begin
                    n_new.iv = sav_rd.iv;
                    n_new.h  = sav_rd.h;
                    n_new.dl = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
                    n_ins_exp = 1'b1;
                    n_pos = r_occ;
                    n_state = S_ARD;
                end
            end
            S_HRD: begin
                tab_ra = '0;
                n_state = S_HFIN;
            end
            S_HFIN: begin
                if (out_free) begin
                    dly_dl = tab_rd.dl;
                    n_out = (r_occ == '0 || tab_rd.dl == '0)
                        ? t_result'{kind: K_NOARM, h: '0, delay: '0, last: 1'b1}
                        : t_result'{kind: K_ARM, h: '0, delay: dly, last: 1'b1};
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    tab_ra = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // keep the stalled compare reading the same entry
        if (r_state == S_ECMP && !n_ovalid && n_state == S_ECMP) begin
            tab_ra = r_pos[IDX_BITS-1:0];
        end
        if (r_state == S_ECMP && n_state == S_ECMP) begin
            tab_ra = r_pos[IDX_BITS-1:0];
        end
        if (r_state == S_ERD) begin
            tab_ra = r_pos[IDX_BITS-1:0];
        end
        if (r_state == S_ECMP && n_state == S_CRD) begin
            tab_ra = r_k[IDX_BITS-1:0];
        end
        if (r_state == S_ECMP && n_state == S_ERD) begin
            tab_ra = IDX_BITS'(r_pos + 1'b1);
        end
        if (r_state == S_ERD && n_state == S_CRD) begin
            tab_ra = r_k[IDX_BITS-1:0];
        end
        if (r_state == S_RNXT && n_state == S_RRD) begin
            sav_ra = r_j[IDX_BITS-1:0];
        end
        if (r_state == S_AWR && !(out_free || r_ins_exp)) begin
            tab_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ <= '0;
            r_ovalid <= 1'b0;
            r_min <= MIN_ARM_RESET;
        end else begin
            r_state <= n_state;
            r_occ <= n_occ;
            r_ovalid <= n_ovalid;
            if (psel && penable && pwrite && paddr == 2'd0) begin
                r_min <= pwdata;
            end
        end
        r_now <= n_now; r_new <= n_new; r_pos <= n_pos; r_k <= n_k; r_j <= n_j;
        r_ins_exp <= n_ins_exp; r_out <= n_out;
    end
endmodule
